@@ src/ecal_pkg.sv @@
// Shared types, constants and tables for the EU local calendar pipeline.
package ecal_pkg;

  // Register stages in each pipeline section.
  localparam int SPLIT_NS = 2;
  localparam int CIVIL_NS = 7;
  localparam int DST_NS   = 6;
  localparam int TOD_NS   = 4;

  // Time and calendar constants.
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [15:0] LAST_DAY      = 16'd49710;  // last day index in 32-bit range
  localparam logic [17:0] WRAP_REST     = 18'd23296;  // 2^32 - LAST_DAY * 86400
  localparam logic [15:0] ERA5_START    = 16'd11017;  // first day of the era from 2000-03-01
  localparam logic [17:0] ERA4_SHIFT    = 18'd135080; // days from 1600-03-01 to 1970-01-01

  // Reciprocal multipliers: M = ceil(2^S / C), exact over the operand ranges used here.
  localparam int unsigned DAY_SH   = 35;
  localparam logic [63:0] DAY_MF   = ((64'd1 << DAY_SH) + 64'd674) / 64'd675;
  localparam logic [25:0] DAY_M    = DAY_MF[25:0];

  localparam int unsigned Q1460_SH = 29;
  localparam logic [63:0] Q1460_MF = ((64'd1 << Q1460_SH) + 64'd1459) / 64'd1460;
  localparam logic [18:0] Q1460_M  = Q1460_MF[18:0];

  localparam int unsigned Q365_SH  = 27;
  localparam logic [63:0] Q365_MF  = ((64'd1 << Q365_SH) + 64'd364) / 64'd365;
  localparam logic [18:0] Q365_M   = Q365_MF[18:0];

  localparam int unsigned Q153_SH  = 19;
  localparam logic [63:0] Q153_MF  = ((64'd1 << Q153_SH) + 64'd152) / 64'd153;
  localparam logic [11:0] Q153_M   = Q153_MF[11:0];

  localparam int unsigned Q7_SH    = 20;
  localparam logic [63:0] Q7_MF    = ((64'd1 << Q7_SH) + 64'd6) / 64'd7;
  localparam logic [17:0] Q7_M     = Q7_MF[17:0];

  localparam int unsigned Q3600_SH = 29;
  localparam logic [63:0] Q3600_MF = ((64'd1 << Q3600_SH) + 64'd3599) / 64'd3600;
  localparam logic [17:0] Q3600_M  = Q3600_MF[17:0];

  localparam int unsigned Q60_SH   = 18;
  localparam logic [63:0] Q60_MF   = ((64'd1 << Q60_SH) + 64'd59) / 64'd60;
  localparam logic [12:0] Q60_M    = Q60_MF[12:0];

  // Day count, time of day and summer flag that travel beside the date conversion.
  typedef struct packed {
    logic [15:0] days;
    logic [16:0] rest;
    logic        summer;
  } ecal_side_t;

  // Civil date; doy counts days from March 1 of the March-based year.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  doy;
  } ecal_date_t;

  // First day-of-year of each March-based month.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

@@ src/ecal_split.sv @@
// Splits a 32-bit second count into a day index and the seconds within that day.
module ecal_split (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  logic [31:0]          up_utc,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output logic [15:0]          dn_days,
  output ecal_pkg::ecal_side_t dn_side
);

  logic [ecal_pkg::SPLIT_NS-1:0] v_r;
  logic [ecal_pkg::SPLIT_NS-1:0] en;

  logic [31:0] utc1_r;
  logic [15:0] days1_r;
  logic [15:0] days2_r;
  logic [16:0] rest2_r;

  logic [50:0] day_prod;
  logic [31:0] rest_full;

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[ecal_pkg::SPLIT_NS-1] = !v_r[ecal_pkg::SPLIT_NS-1] || !dn_stall;
    for (int k = ecal_pkg::SPLIT_NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[ecal_pkg::SPLIT_NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < ecal_pkg::SPLIT_NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Day index by reciprocal multiply: utc / 86400 = (utc >> 7) / 675.
  always_comb begin
    day_prod  = {26'd0, up_utc[31:7]} * {25'd0, ecal_pkg::DAY_M};
    rest_full = utc1_r - (32'(days1_r) * 32'(ecal_pkg::SECS_PER_DAY));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      utc1_r  <= up_utc;
      days1_r <= day_prod[50:35];
    end
    if (en[1]) begin
      days2_r <= days1_r;
      rest2_r <= rest_full[16:0];
    end
  end

  assign dn_days        = days2_r;
  assign dn_side.days   = days2_r;
  assign dn_side.rest   = rest2_r;
  assign dn_side.summer = 1'b0;

endmodule

@@ src/ecal_civil.sv @@
// Pipelined civil date from a day index since 1970-01-01 (era arithmetic).
module ecal_civil (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  logic [15:0]          up_days,
  input  ecal_pkg::ecal_side_t up_side,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output ecal_pkg::ecal_date_t dn_date,
  output ecal_pkg::ecal_side_t dn_side
);

  logic [ecal_pkg::CIVIL_NS-1:0] v_r;
  logic [ecal_pkg::CIVIL_NS-1:0] en;
  ecal_pkg::ecal_side_t side_r [ecal_pkg::CIVIL_NS];

  logic        hi1_r, hi2_r, hi3_r, hi4_r, hi5_r, hi6_r;
  logic [17:0] doe1_r, doe2_r, doe3_r, doe4_r;
  logic [6:0]  q2_r;
  logic [2:0]  c2_r;
  logic        top2_r;
  logic [17:0] n3_r;
  logic [8:0]  yoe4_r, yoe5_r, yoe6_r;
  logic [8:0]  doy5_r, doy6_r;
  logic [3:0]  mp6_r;
  ecal_pkg::ecal_date_t date7_r;

  logic        hi_in;
  logic [17:0] doe_in;
  logic [36:0] prod1460;
  logic [2:0]  c36524;
  logic [17:0] n_nxt;
  logic [36:0] prod365;
  logic [1:0]  c100;
  logic [17:0] base;
  logic [17:0] doy_full;
  logic [10:0] mx;
  logic [22:0] prod153;
  logic [3:0]  month_nxt;
  logic [8:0]  day_full;
  logic [11:0] year_nxt;

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[ecal_pkg::CIVIL_NS-1] = !v_r[ecal_pkg::CIVIL_NS-1] || !dn_stall;
    for (int k = ecal_pkg::CIVIL_NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[ecal_pkg::CIVIL_NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < ecal_pkg::CIVIL_NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Sideband travels beside the date stages unchanged.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= up_side;
    end
    for (int k = 1; k < ecal_pkg::CIVIL_NS; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Era selection and day of era; only eras 4 and 5 occur in range.
  always_comb begin
    hi_in  = (up_days >= ecal_pkg::ERA5_START);
    doe_in = hi_in ? (18'(up_days) - 18'(ecal_pkg::ERA5_START))
                   : (18'(up_days) + ecal_pkg::ERA4_SHIFT);
  end

  // Leap corrections: doe / 1460 by reciprocal, doe / 36524 by compares.
  always_comb begin
    prod1460 = {19'd0, doe1_r} * {18'd0, ecal_pkg::Q1460_M};
    c36524   = 3'(doe1_r >= 18'd36524) + 3'(doe1_r >= 18'd73048)
             + 3'(doe1_r >= 18'd109572) + 3'(doe1_r >= 18'd146096);
    n_nxt    = doe2_r - 18'(q2_r) + 18'(c2_r) - 18'(top2_r);
    prod365  = {19'd0, n3_r} * {18'd0, ecal_pkg::Q365_M};
  end

  // Day of year within the March-based year.
  always_comb begin
    c100     = 2'(yoe4_r >= 9'd100) + 2'(yoe4_r >= 9'd200) + 2'(yoe4_r >= 9'd300);
    base     = (18'(yoe4_r) * 18'd365) + 18'(yoe4_r[8:2]) - 18'(c100);
    doy_full = doe4_r - base;
    mx       = (11'(doy5_r) * 11'd5) + 11'd2;
    prod153  = {12'd0, mx} * {11'd0, ecal_pkg::Q153_M};
  end

  // Month, day and year from the March-based month index.
  always_comb begin
    month_nxt = (mp6_r < 4'd10) ? (mp6_r + 4'd3) : (mp6_r - 4'd9);
    day_full  = doy6_r - ecal_pkg::month_start(mp6_r) + 9'd1;
    year_nxt  = 12'(yoe6_r) + (hi6_r ? 12'd2000 : 12'd1600) + 12'(month_nxt <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hi1_r  <= hi_in;
      doe1_r <= doe_in;
    end
    if (en[1]) begin
      hi2_r  <= hi1_r;
      doe2_r <= doe1_r;
      q2_r   <= prod1460[35:29];
      c2_r   <= c36524;
      top2_r <= (doe1_r == 18'd146096);
    end
    if (en[2]) begin
      hi3_r  <= hi2_r;
      doe3_r <= doe2_r;
      n3_r   <= n_nxt;
    end
    if (en[3]) begin
      hi4_r  <= hi3_r;
      doe4_r <= doe3_r;
      yoe4_r <= prod365[35:27];
    end
    if (en[4]) begin
      hi5_r  <= hi4_r;
      yoe5_r <= yoe4_r;
      doy5_r <= doy_full[8:0];
    end
    if (en[5]) begin
      hi6_r  <= hi5_r;
      yoe6_r <= yoe5_r;
      doy6_r <= doy5_r;
      mp6_r  <= prod153[22:19];
    end
    if (en[6]) begin
      date7_r.year  <= year_nxt;
      date7_r.month <= month_nxt;
      date7_r.day   <= day_full[4:0];
      date7_r.doy   <= doy6_r;
    end
  end

  assign dn_date = date7_r;
  assign dn_side = side_r[ecal_pkg::CIVIL_NS-1];

endmodule

@@ src/ecal_dst.sv @@
// Summer-time decision and shift of the day index and time of day to local time.
module ecal_dst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  ecal_pkg::ecal_date_t up_date,
  input  ecal_pkg::ecal_side_t up_side,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output logic [15:0]          dn_days,
  output ecal_pkg::ecal_side_t dn_side
);

  logic [ecal_pkg::DST_NS-1:0] v_r;
  logic [ecal_pkg::DST_NS-1:0] en;
  ecal_pkg::ecal_side_t side_r [ecal_pkg::DST_NS-1];
  logic [2:0] m3_r;

  logic [16:0] xm1_r, xo1_r, xm2_r, xo2_r;
  logic [14:0] qm2_r, qo2_r;
  logic [16:0] sday3_r, eday3_r;
  logic        summer4_r, summer5_r;
  logic [17:0] restl5_r;
  ecal_pkg::ecal_side_t out6_r;

  logic [16:0] dd;
  logic [34:0] prod_m, prod_o;
  logic [16:0] rm, ro;
  logic [16:0] days_x;
  logic        after_start, before_end;
  logic        wrap, carry;

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[ecal_pkg::DST_NS-1] = !v_r[ecal_pkg::DST_NS-1] || !dn_stall;
    for (int k = ecal_pkg::DST_NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[ecal_pkg::DST_NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < ecal_pkg::DST_NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // UTC day index, time of day and the March-or-later flag ride along.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= up_side;
      m3_r[0]   <= (up_date.month >= 4'd3);
    end
    for (int k = 1; k < ecal_pkg::DST_NS - 1; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (en[k]) begin
        m3_r[k] <= m3_r[k-1];
      end
    end
  end

  // March 31 and October 31 of the current year, plus four for the weekday.
  assign dd = 17'(up_side.days) - 17'(up_date.doy);

  // Weekday of each month end by reciprocal multiply, then last Sunday.
  always_comb begin
    prod_m = {18'd0, xm1_r} * {17'd0, ecal_pkg::Q7_M};
    prod_o = {18'd0, xo1_r} * {17'd0, ecal_pkg::Q7_M};
    rm     = xm2_r - (17'(qm2_r) * 17'd7);
    ro     = xo2_r - (17'(qo2_r) * 17'd7);
  end

  // Window test: start is inclusive and end exclusive at 01:00 UTC.
  always_comb begin
    days_x      = 17'(side_r[2].days);
    after_start = (days_x > sday3_r)
                || ((days_x == sday3_r) && (side_r[2].rest >= 17'(ecal_pkg::SECS_PER_HOUR)));
    before_end  = (days_x < eday3_r)
                || ((days_x == eday3_r) && (side_r[2].rest < 17'(ecal_pkg::SECS_PER_HOUR)));
  end

  // Carry into the next day, or wrap past the top of the 32-bit range.
  always_comb begin
    wrap  = (side_r[4].days == ecal_pkg::LAST_DAY) && (restl5_r >= ecal_pkg::WRAP_REST);
    carry = (restl5_r >= 18'(ecal_pkg::SECS_PER_DAY));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xm1_r <= dd + 17'd34;
      xo1_r <= dd + 17'd248;
    end
    if (en[1]) begin
      xm2_r <= xm1_r;
      xo2_r <= xo1_r;
      qm2_r <= prod_m[34:20];
      qo2_r <= prod_o[34:20];
    end
    if (en[2]) begin
      sday3_r <= xm2_r - 17'd4 - 17'(rm[2:0]);
      eday3_r <= xo2_r - 17'd4 - 17'(ro[2:0]);
    end
    if (en[3]) begin
      summer4_r <= m3_r[2] && after_start && before_end;
    end
    if (en[4]) begin
      summer5_r <= summer4_r;
      restl5_r  <= 18'(side_r[3].rest)
                 + (summer4_r ? 18'(2 * ecal_pkg::SECS_PER_HOUR)
                              : 18'(ecal_pkg::SECS_PER_HOUR));
    end
    if (en[5]) begin
      out6_r.summer <= summer5_r;
      if (wrap) begin
        out6_r.days <= 16'd0;
        out6_r.rest <= 17'(restl5_r - ecal_pkg::WRAP_REST);
      end else if (carry) begin
        out6_r.days <= side_r[4].days + 16'd1;
        out6_r.rest <= 17'(restl5_r - 18'(ecal_pkg::SECS_PER_DAY));
      end else begin
        out6_r.days <= side_r[4].days;
        out6_r.rest <= restl5_r[16:0];
      end
    end
  end

  assign dn_days = out6_r.days;
  assign dn_side = out6_r;

endmodule

@@ src/ecal_tod.sv @@
// Local hour, minute, second and weekday, and the result register.
module ecal_tod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  ecal_pkg::ecal_date_t up_date,
  input  ecal_pkg::ecal_side_t up_side,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output logic [1:0]           dn_offset_hours,
  output logic [11:0]          dn_year,
  output logic [3:0]           dn_month,
  output logic [4:0]           dn_day,
  output logic [4:0]           dn_hour,
  output logic [5:0]           dn_minute,
  output logic [5:0]           dn_second,
  output logic [2:0]           dn_weekday
);

  logic [ecal_pkg::TOD_NS-1:0] v_r;
  logic [ecal_pkg::TOD_NS-1:0] en;
  ecal_pkg::ecal_date_t date_r [ecal_pkg::TOD_NS-1];
  logic [ecal_pkg::TOD_NS-2:0] summer_r;

  logic [4:0]  hour1_r, hour2_r, hour3_r;
  logic [16:0] rest1_r;
  logic [16:0] wx1_r;
  logic [14:0] wq1_r;
  logic [11:0] mrem2_r, mrem3_r;
  logic [2:0]  wday2_r, wday3_r;
  logic [5:0]  min3_r;

  logic [1:0]  off4_r;
  logic [11:0] year4_r;
  logic [3:0]  month4_r;
  logic [4:0]  day4_r;
  logic [4:0]  hour4_r;
  logic [5:0]  min4_r;
  logic [5:0]  sec4_r;
  logic [2:0]  wday4_r;

  logic [16:0] wx_in;
  logic [34:0] prod_h;
  logic [34:0] prod_w;
  logic [16:0] mrem_full;
  logic [16:0] wd_full;
  logic [24:0] prod_min;
  logic [11:0] sec_full;

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[ecal_pkg::TOD_NS-1] = !v_r[ecal_pkg::TOD_NS-1] || !dn_stall;
    for (int k = ecal_pkg::TOD_NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[ecal_pkg::TOD_NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < ecal_pkg::TOD_NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Date and summer flag ride along to the result register.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      date_r[0]   <= up_date;
      summer_r[0] <= up_side.summer;
    end
    for (int k = 1; k < ecal_pkg::TOD_NS - 1; k++) begin
      if (en[k]) begin
        date_r[k]   <= date_r[k-1];
        summer_r[k] <= summer_r[k-1];
      end
    end
  end

  // Hour and weekday quotients by reciprocal multiply; 1970-01-01 was a Thursday.
  always_comb begin
    wx_in  = 17'(up_side.days) + 17'd4;
    prod_h = {18'd0, up_side.rest} * {17'd0, ecal_pkg::Q3600_M};
    prod_w = {18'd0, wx_in} * {17'd0, ecal_pkg::Q7_M};
  end

  // Remainders, then minute quotient and second remainder.
  always_comb begin
    mrem_full = rest1_r - (17'(hour1_r) * 17'(ecal_pkg::SECS_PER_HOUR));
    wd_full   = wx1_r - (17'(wq1_r) * 17'd7);
    prod_min  = {13'd0, mrem2_r} * {12'd0, ecal_pkg::Q60_M};
    sec_full  = mrem3_r - (12'(min3_r) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hour1_r <= prod_h[33:29];
      rest1_r <= up_side.rest;
      wx1_r   <= wx_in;
      wq1_r   <= prod_w[34:20];
    end
    if (en[1]) begin
      hour2_r <= hour1_r;
      mrem2_r <= mrem_full[11:0];
      wday2_r <= wd_full[2:0];
    end
    if (en[2]) begin
      hour3_r <= hour2_r;
      mrem3_r <= mrem2_r;
      wday3_r <= wday2_r;
      min3_r  <= prod_min[23:18];
    end
    if (en[3]) begin
      off4_r   <= summer_r[2] ? 2'd2 : 2'd1;
      year4_r  <= date_r[2].year;
      month4_r <= date_r[2].month;
      day4_r   <= date_r[2].day;
      hour4_r  <= hour3_r;
      min4_r   <= min3_r;
      sec4_r   <= sec_full[5:0];
      wday4_r  <= wday3_r;
    end
  end

  assign dn_offset_hours = off4_r;
  assign dn_year         = year4_r;
  assign dn_month        = month4_r;
  assign dn_day          = day4_r;
  assign dn_hour         = hour4_r;
  assign dn_minute       = min4_r;
  assign dn_second       = sec4_r;
  assign dn_weekday      = wday4_r;

endmodule

@@ src/epoch_to_local_calendar_eu_dst_top.sv @@
// Top level: Unix UTC seconds to EU local civil date, time and weekday.
// Throughput is one transaction per cycle; every stage holds its own valid bit,
// so empty stages fill while a result waits, and out_stall backs up stage by stage.
// Reset (synchronous, active low) empties the pipeline; no other state exists.
module epoch_to_local_calendar_eu_dst_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_utc_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_offset_hours,
  output logic [11:0] out_local_year,
  output logic [3:0]  out_local_month,
  output logic [4:0]  out_local_day,
  output logic [4:0]  out_local_hour,
  output logic [5:0]  out_local_minute,
  output logic [5:0]  out_local_second,
  output logic [2:0]  out_local_weekday
);

  logic                 sp_valid, sp_stall;
  logic [15:0]          sp_days;
  ecal_pkg::ecal_side_t sp_side;

  logic                 c1_valid, c1_stall;
  ecal_pkg::ecal_date_t c1_date;
  ecal_pkg::ecal_side_t c1_side;

  logic                 ds_valid, ds_stall;
  logic [15:0]          ds_days;
  ecal_pkg::ecal_side_t ds_side;

  logic                 c2_valid, c2_stall;
  ecal_pkg::ecal_date_t c2_date;
  ecal_pkg::ecal_side_t c2_side;

  // UTC day index and time of day.
  ecal_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_utc   (in_utc_seconds),
    .dn_valid (sp_valid),
    .dn_stall (sp_stall),
    .dn_days  (sp_days),
    .dn_side  (sp_side)
  );

  // UTC civil date, used for the summer-time window.
  ecal_civil u_civil_utc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sp_valid),
    .up_stall (sp_stall),
    .up_days  (sp_days),
    .up_side  (sp_side),
    .dn_valid (c1_valid),
    .dn_stall (c1_stall),
    .dn_date  (c1_date),
    .dn_side  (c1_side)
  );

  // Offset decision and shift to local day index and time of day.
  ecal_dst u_dst (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c1_valid),
    .up_stall (c1_stall),
    .up_date  (c1_date),
    .up_side  (c1_side),
    .dn_valid (ds_valid),
    .dn_stall (ds_stall),
    .dn_days  (ds_days),
    .dn_side  (ds_side)
  );

  // Local civil date.
  ecal_civil u_civil_local (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ds_valid),
    .up_stall (ds_stall),
    .up_days  (ds_days),
    .up_side  (ds_side),
    .dn_valid (c2_valid),
    .dn_stall (c2_stall),
    .dn_date  (c2_date),
    .dn_side  (c2_side)
  );

  // Local time of day, weekday and result register.
  ecal_tod u_tod (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (c2_valid),
    .up_stall        (c2_stall),
    .up_date         (c2_date),
    .up_side         (c2_side),
    .dn_valid        (out_valid),
    .dn_stall        (out_stall),
    .dn_offset_hours (out_offset_hours),
    .dn_year         (out_local_year),
    .dn_month        (out_local_month),
    .dn_day          (out_local_day),
    .dn_hour         (out_local_hour),
    .dn_minute       (out_local_minute),
    .dn_second       (out_local_second),
    .dn_weekday      (out_local_weekday)
  );

endmodule

@@ dv/epoch_to_local_calendar_eu_dst_top_tb.sv @@
// Testbench for the EU local calendar pipeline: directed and random Unix times checked against a predictor.
module epoch_to_local_calendar_eu_dst_top_tb;

  localparam int CLK_HALF   = 5;
  localparam int N_RANDOM   = 850;
  localparam int MID_DRAIN  = 450;
  localparam int CALM_TAIL  = 120;
  localparam int PIPE_DEPTH = 26;
  localparam int MAX_PRINTS = 60;

  // One expected local time, with the UTC input that produced it.
  typedef struct packed {
    logic [31:0] src_utc;
    logic [1:0]  offset_hours;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } local_time_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_utc_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_offset_hours;
  logic [11:0] out_local_year;
  logic [3:0]  out_local_month;
  logic [4:0]  out_local_day;
  logic [4:0]  out_local_hour;
  logic [5:0]  out_local_minute;
  logic [5:0]  out_local_second;
  logic [2:0]  out_local_weekday;

  logic [31:0] utc_feed_q[$];
  local_time_t local_time_q[$];
  local_time_t want;
  int          n_issued = 0;
  int          n_in_acc = 0;
  int          n_directed = 0;
  int          n_errors = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          send_bursty = 1'b1;
  bit          stall_bursty = 1'b1;

  epoch_to_local_calendar_eu_dst_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_utc_seconds    (in_utc_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_offset_hours  (out_offset_hours),
    .out_local_year    (out_local_year),
    .out_local_month   (out_local_month),
    .out_local_day     (out_local_day),
    .out_local_hour    (out_local_hour),
    .out_local_minute  (out_local_minute),
    .out_local_second  (out_local_second),
    .out_local_weekday (out_local_weekday)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Day number since 1970-01-01 of a proleptic Gregorian date (year 1970 or later).
  function automatic bit [63:0] days_from_date(input bit [63:0] y, input bit [63:0] m,
                                               input bit [63:0] d);
    bit [63:0] ya, era, yoe, mm, doy, doe;
    ya  = (m <= 2) ? y - 1 : y;
    era = ya / 400;
    yoe = ya - era * 400;
    mm  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mm + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Civil date of a day number, using March-based years inside 400-year eras.
  function automatic void date_from_days(input bit [63:0] days, output bit [63:0] y,
                                         output bit [63:0] m, output bit [63:0] d);
    bit [63:0] z, era, doe, yoe, doy, mp;
    z   = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // UTC second of 01:00 on the last Sunday of a 31-day month.
  function automatic bit [63:0] dst_switch_utc(input bit [63:0] y, input bit [63:0] m);
    bit [63:0] last_day, wday;
    last_day = days_from_date(y, m, 31);
    wday     = (last_day + 4) % 7;
    return (last_day - wday) * 86400 + 3600;
  endfunction

  // Local civil time for one UTC input, with the summer offset taken from the UTC year.
  function automatic local_time_t to_local_time(input logic [31:0] utc);
    bit [63:0]   y, m, d, off, t, days, rest;
    local_time_t r;
    date_from_days(64'(utc / 86400), y, m, d);
    off  = (utc >= dst_switch_utc(y, 3) && utc < dst_switch_utc(y, 10)) ? 2 : 1;
    t    = (utc + off * 3600) & 64'hFFFF_FFFF;
    days = t / 86400;
    rest = t % 86400;
    date_from_days(days, y, m, d);
    r.src_utc      = utc;
    r.offset_hours = off[1:0];
    r.year         = y[11:0];
    r.month        = m[3:0];
    r.day          = d[4:0];
    r.hour         = 5'(rest / 3600);
    r.minute       = 6'((rest % 3600) / 60);
    r.second       = 6'(rest % 60);
    r.weekday      = 3'((days + 4) % 7);
    return r;
  endfunction

  // Random times, weighted toward changeovers, midnights, new year and the top of range.
  function automatic logic [31:0] random_utc();
    bit [63:0] yr, base, dn;
    int        pick;
    pick = $urandom_range(0, 99);
    yr   = 64'($urandom_range(1970, 2105));
    if (pick < 35) return $urandom();
    if (pick < 65) begin
      base = dst_switch_utc(yr, ($urandom_range(0, 1) != 0) ? 10 : 3);
      return 32'(base + $urandom_range(0, 14400) - 7200);
    end
    if (pick < 75) begin
      base = days_from_date(yr, 1, 1) * 86400;
      return 32'(base - $urandom_range(0, 7260));
    end
    if (pick < 88) begin
      dn = 64'($urandom_range(0, 49709));
      return 32'(dn * 86400 + $urandom_range(75540, 79260));
    end
    return 32'hFFFF_FFFF - $urandom_range(0, 20000);
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Input driver: presents the next transaction once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || n_in_acc == n_issued) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if ((n_issued == n_directed || n_issued == MID_DRAIN) &&
                     local_time_q.size() != 0) begin
          // Hold off until the pipeline has handed back every pending result.
          in_valid <= 1'b0;
        end else if (utc_feed_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (send_bursty && utc_feed_q.size() > CALM_TAIL &&
                     $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_utc_seconds <= utc_feed_q.pop_front();
          n_issued++;
        end
        if ($urandom_range(0, 39) == 0) send_bursty = !send_bursty;
      end
    end
  end

  // Result-side stall in random bursts, quiet toward the end of the run.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_bursty && utc_feed_q.size() > CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 39) == 0) stall_bursty = !stall_bursty;
    end
  end

  // Monitor: check each result transaction, then record each accepted input transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (local_time_q.size() == 0) begin
          report_mismatch("result transaction with nothing pending");
        end else begin
          want = local_time_q.pop_front();
          if (out_offset_hours !== want.offset_hours)
            report_mismatch($sformatf("utc %0d offset_hours got %0d want %0d",
                                      want.src_utc, out_offset_hours, want.offset_hours));
          if (out_local_year !== want.year)
            report_mismatch($sformatf("utc %0d year got %0d want %0d",
                                      want.src_utc, out_local_year, want.year));
          if (out_local_month !== want.month)
            report_mismatch($sformatf("utc %0d month got %0d want %0d",
                                      want.src_utc, out_local_month, want.month));
          if (out_local_day !== want.day)
            report_mismatch($sformatf("utc %0d day got %0d want %0d",
                                      want.src_utc, out_local_day, want.day));
          if (out_local_hour !== want.hour)
            report_mismatch($sformatf("utc %0d hour got %0d want %0d",
                                      want.src_utc, out_local_hour, want.hour));
          if (out_local_minute !== want.minute)
            report_mismatch($sformatf("utc %0d minute got %0d want %0d",
                                      want.src_utc, out_local_minute, want.minute));
          if (out_local_second !== want.second)
            report_mismatch($sformatf("utc %0d second got %0d want %0d",
                                      want.src_utc, out_local_second, want.second));
          if (out_local_weekday !== want.weekday)
            report_mismatch($sformatf("utc %0d weekday got %0d want %0d",
                                      want.src_utc, out_local_weekday, want.weekday));
        end
      end
      if (in_valid && !in_stall) begin
        local_time_q.push_back(to_local_time(in_utc_seconds));
        n_in_acc <= n_in_acc + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    bit [63:0] sw_start, sw_end;
    int        years[4];
    int        wait_left;
    years = '{1970, 2000, 2038, 2105};

    // Changeover instants and the second before each, over several years.
    foreach (years[i]) begin
      sw_start = dst_switch_utc(64'(years[i]), 3);
      sw_end   = dst_switch_utc(64'(years[i]), 10);
      utc_feed_q.push_back(32'(sw_start - 1));
      utc_feed_q.push_back(32'(sw_start));
      utc_feed_q.push_back(32'(sw_end - 1));
      utc_feed_q.push_back(32'(sw_end));
    end
    // Range ends, the local wrap past 2^32 and the last second before it.
    utc_feed_q.push_back(32'h0000_0000);
    utc_feed_q.push_back(32'hFFFF_FFFF);
    utc_feed_q.push_back(32'hFFFF_F1F0);
    utc_feed_q.push_back(32'hFFFF_F1EF);
    // Leap day rolling into March, and New Year reached only in local time.
    utc_feed_q.push_back(32'(days_from_date(2000, 3, 1) * 86400 - 1800));
    utc_feed_q.push_back(32'(days_from_date(2000, 1, 1) * 86400 - 1800));
    n_directed = utc_feed_q.size();

    for (int i = 0; i < N_RANDOM; i++) utc_feed_q.push_back(random_utc());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (utc_feed_q.size() != 0 || n_in_acc != n_issued) @(posedge clk);
    wait_left = 4000;
    while (local_time_q.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (local_time_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", local_time_q.size()));

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
